/* hw/rtl/lkvt_pkg.sv */
`timescale 1ns / 1ps

package lkvt_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic               active;
    logic               mode;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               placed;
    logic               hit;
    logic [KEY_W-1:0]   rkey;
    logic [VALUE_W-1:0] rvalue;
  } token_t;

endpackage

/* hw/rtl/linear_key_value_table.sv */
`timescale 1ns / 1ps
// A request walks the row of cells, one cell per clock, registered at the
// entry and in each cell in turn; the last cell gives its result strobe.
// Busy stays high until the result cycle, so a new request is accepted only
// once the last one reaches its result; the receiver cannot stall the result.
// Synchronous reset empties the table by clearing the entry count and the
// cell pipeline; no clearing pass is needed.

module linear_key_value_table #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [lkvt_pkg::KEY_W-1:0]   key_in,
  input  logic [lkvt_pkg::VALUE_W-1:0] value_in,
  output logic                         done,
  output logic                         hit,
  output logic [lkvt_pkg::KEY_W-1:0]   key_out,
  output logic [lkvt_pkg::VALUE_W-1:0] value_out,
  output logic                         dropped
);

  localparam int CW = $clog2(CAPACITY + 1);

  lkvt_pkg::token_t tok [CAPACITY+1];
  logic [CW-1:0]    count;
  logic             accept;
  logic             appended;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].active <= 1'b0;
    end else begin
      tok[0].active <= accept;
      if (accept) begin
        tok[0].mode   <= mode;
        tok[0].key    <= key_in;
        tok[0].value  <= value_in;
        tok[0].placed <= 1'b0;
        tok[0].hit    <= 1'b0;
        tok[0].rkey   <= '0;
        tok[0].rvalue <= '0;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lkvt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .entry_valid (CW'(i) < count),
      .tok_in      (tok[i]),
      .tok_out     (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (tok[CAPACITY-1].active) begin
      busy <= 1'b0;
    end
  end

  assign appended = done && (tok[CAPACITY].mode == lkvt_pkg::MODE_INSERT)
                    && tok[CAPACITY].placed && !tok[CAPACITY].hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (appended) begin
      count <= count + CW'(1);
    end
  end

  assign done      = tok[CAPACITY].active;
  assign hit       = done && tok[CAPACITY].hit;
  assign key_out   = tok[CAPACITY].rkey;
  assign value_out = tok[CAPACITY].rvalue;
  assign dropped   = done && (tok[CAPACITY].mode == lkvt_pkg::MODE_INSERT)
                     && !tok[CAPACITY].placed;

endmodule

/* hw/rtl/lkvt_cell.sv */
`timescale 1ns / 1ps

module lkvt_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            entry_valid,
  input  lkvt_pkg::token_t tok_in,
  output lkvt_pkg::token_t tok_out
);

  logic [lkvt_pkg::KEY_W-1:0]   key_q;
  logic [lkvt_pkg::VALUE_W-1:0] value_q;
  lkvt_pkg::token_t             tok_next;
  logic                         wr;
  logic                         match;

  assign match = entry_valid && (key_q == tok_in.key);

  always_comb begin
    tok_next = tok_in;
    wr       = 1'b0;
    if (tok_in.active && !tok_in.placed) begin
      if (match) begin
        tok_next.placed = 1'b1;
        tok_next.hit    = 1'b1;
        if (tok_in.mode == lkvt_pkg::MODE_INSERT) begin
          wr = 1'b1;
        end else begin
          tok_next.rkey   = key_q;
          tok_next.rvalue = value_q;
        end
      end else if (!entry_valid && tok_in.mode == lkvt_pkg::MODE_INSERT) begin
        wr              = 1'b1;
        tok_next.placed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key_q   <= tok_in.key;
      value_q <= tok_in.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

/* hw/rtl/lkvt_checker.sv */
`timescale 1ns / 1ps

module lkvt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         hit,
  input logic [lkvt_pkg::KEY_W-1:0]   key_out,
  input logic [lkvt_pkg::VALUE_W-1:0] value_out,
  input logic                         dropped
);

  // A transfer in holds off further requests until its result appears.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted request");

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy still high during the result cycle");

  assert property (@(posedge clk) disable iff (rst) dropped |-> (done && !hit))
    else $error("dropped raised together with hit or outside a result");

  assert property (@(posedge clk) disable iff (rst)
                   (done && !hit) |-> (key_out == '0 && value_out == '0))
    else $error("nonzero key or value on a result without a hit");

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .hit       (hit),
  .key_out   (key_out),
  .value_out (value_out),
  .dropped   (dropped)
);
